### sv/ntc_pkg.sv
// package for the numeric type converter: beat structs, type codes and helpers
// no dependencies
`default_nettype none
package ntc_pkg;

  localparam logic [3:0] TY_I32 = 4'd0;
  localparam logic [3:0] TY_U32 = 4'd1;
  localparam logic [3:0] TY_I16 = 4'd2;
  localparam logic [3:0] TY_U16 = 4'd3;
  localparam logic [3:0] TY_I8  = 4'd4;
  localparam logic [3:0] TY_U8  = 4'd5;
  localparam logic [3:0] TY_F64 = 4'd6;
  localparam logic [3:0] TY_F32 = 4'd7;
  localparam logic [3:0] TY_I64 = 4'd8;
  localparam logic [3:0] TY_U64 = 4'd9;

  typedef struct packed {
    logic [63:0] value_bits;
    logic [3:0]  in_type;
    logic [3:0]  dst_type;
  } ntc_in_t;

  typedef struct packed {
    logic [63:0] result_bits;
    logic        status;
  } ntc_out_t;

  function automatic logic type_valid(input logic [3:0] t);
    type_valid = (t <= TY_U64);
  endfunction

  function automatic logic type_signed(input logic [3:0] t);
    type_signed = (t == TY_I32) || (t == TY_I16) || (t == TY_I8) || (t == TY_I64);
  endfunction

  function automatic logic type_float(input logic [3:0] t);
    type_float = (t == TY_F64) || (t == TY_F32);
  endfunction

  // width mask of a type code
  function automatic logic [63:0] type_mask(input logic [3:0] t);
    logic [63:0] m;
    m = '1;
    unique case (t)
      TY_I32, TY_U32, TY_F32: m = 64'h0000_0000_FFFF_FFFF;
      TY_I16, TY_U16:         m = 64'h0000_0000_0000_FFFF;
      TY_I8, TY_U8:           m = 64'h0000_0000_0000_00FF;
      default:                m = '1;
    endcase
    type_mask = m;
  endfunction

  // leading zero count, 64 when zero
  function automatic logic [6:0] lzc64(input logic [63:0] x);
    logic [6:0] n;
    logic       found;
    n = 7'd64;
    found = 1'b0;
    for (int i = 63; i >= 0; i--) begin
      if (x[i] && !found) begin
        n = 7'(63 - i);
        found = 1'b1;
      end
    end
    lzc64 = n;
  endfunction

endpackage
`default_nettype wire

### sv/ntc_int2flt.sv
// integer to binary64 / binary32 conversion, nearest even
// depends on ntc_pkg
`default_nettype none
module ntc_int2flt (
  input  wire logic [63:0] ext_i,
  input  wire logic        neg_i,
  input  wire logic        to_f64_i,
  output logic      [63:0] flt_o
);

  logic [63:0] mag, norm;
  logic [6:0]  lz;
  logic [5:0]  p;
  logic        rnd64, rnd32;
  logic [53:0] sum64;
  logic [24:0] sum32;
  logic [63:0] enc64;
  logic [31:0] enc32;
  logic [10:0] exp64;
  logic [7:0]  exp32;

  always_comb begin
    mag   = neg_i ? (64'd0 - ext_i) : ext_i;
    lz    = ntc_pkg::lzc64(mag);
    norm  = mag << lz[5:0];
    p     = 6'(7'd63 - lz);
    rnd64 = norm[10] && ((|norm[9:0]) || norm[11]);
    sum64 = {1'b0, norm[63:11]} + {53'd0, rnd64};
    exp64 = 11'd1022 + {5'd0, p};
    enc64 = {1'b0, exp64, 52'd0} + {10'd0, sum64};
    rnd32 = norm[39] && ((|norm[38:0]) || norm[40]);
    sum32 = {1'b0, norm[63:40]} + {24'd0, rnd32};
    exp32 = 8'd126 + {2'd0, p};
    enc32 = {1'b0, exp32, 23'd0} + {7'd0, sum32};
    if (mag == 64'd0) begin
      flt_o = '0;
    end else if (to_f64_i) begin
      flt_o = {neg_i, enc64[62:0]};
    end else begin
      flt_o = {32'd0, neg_i, enc32[30:0]};
    end
  end

endmodule
`default_nettype wire

### sv/ntc_flt_cvt.sv
// float source conversion: binary32 widening, binary64 narrowing, float to integer
// depends on ntc_pkg
`default_nettype none
module ntc_flt_cvt (
  input  wire logic [63:0] v_i,
  input  wire logic        from_f32_i,
  input  wire logic [3:0]  dst_type_i,
  output logic      [63:0] res_o
);

  logic        s32;
  logic [7:0]  e32;
  logic [22:0] f32;
  logic [6:0]  lz;
  logic [4:0]  k;
  logic [22:0] fn;
  logic [63:0] d;
  logic        s;
  logic [10:0] e;
  logic [51:0] f;
  logic [52:0] m;
  // narrowing
  logic        nrm;
  logic [5:0]  shamt;
  logic [11:0] dsh;
  logic [127:0] wide;
  logic        rnd;
  logic [35:0] enc;
  logic [31:0] f32r;
  // to integer
  logic [115:0] tmp;
  logic [63:0] mag, lim;
  logic        big;
  logic [10:0] sh;
  logic [63:0] ires;

  always_comb begin
    s32 = v_i[31];
    e32 = v_i[30:23];
    f32 = v_i[22:0];
    lz  = ntc_pkg::lzc64({f32, 41'd0});
    k   = 5'(lz + 7'd1);
    fn  = 23'(f32 << k);
    if (e32 == 8'hFF) begin
      d = {s32, 11'h7FF, (f32 != 23'd0), f32[21:0], 29'd0};
      d[51] = (f32 != 23'd0) | f32[22];
    end else if (e32 == 8'd0 && f32 == 23'd0) begin
      d = {s32, 63'd0};
    end else if (e32 == 8'd0) begin
      d = {s32, 11'(11'd897 - {6'd0, k}), fn, 29'd0};
    end else begin
      d = {s32, 11'({3'd0, e32} + 11'd896), f32, 29'd0};
    end
    if (!from_f32_i) d = v_i;

    s = d[63];
    e = d[62:52];
    f = d[51:0];
    m = {1'b1, f};

    // binary64 to binary32
    nrm   = (e >= 11'd897);
    dsh   = 12'd926 - {1'b0, e};
    shamt = nrm ? 6'd29 : ((e < 11'd863) ? 6'd63 : dsh[5:0]);
    wide  = {11'd0, m, 64'd0} >> shamt;
    rnd   = wide[63] && ((|wide[62:0]) || wide[64]);
    enc   = (nrm ? {1'b0, 11'(e - 11'd897), 24'd0} >> 1 : 36'd0)
            + {11'd0, wide[88:64]} + {35'd0, rnd};
    if (e == 11'h7FF) begin
      f32r = {s, 8'hFF, (f != 52'd0), (f != 52'd0) ? f[50:29] : 22'd0};
      f32r[22] = (f != 52'd0);
    end else if (e == 11'd0) begin
      f32r = {s, 31'd0};
    end else if (enc >= {5'd0, 8'hFF, 23'd0}) begin
      f32r = {s, 8'hFF, 23'd0};
    end else begin
      f32r = {s, enc[30:0]};
    end

    // binary64 to signed integer, truncate and saturate
    sh  = e - 11'd1023;
    tmp = {63'd0, m} << sh[5:0];
    big = (e == 11'h7FF) || (e >= 11'd1087);
    mag = (e >= 11'd1023 && !big) ? tmp[115:52] : 64'd0;
    unique case (dst_type_i)
      ntc_pkg::TY_I8, ntc_pkg::TY_U8:   lim = 64'h80;
      ntc_pkg::TY_I16, ntc_pkg::TY_U16: lim = 64'h8000;
      ntc_pkg::TY_I32, ntc_pkg::TY_U32: lim = 64'h8000_0000;
      default:                          lim = 64'h8000_0000_0000_0000;
    endcase
    if (e == 11'h7FF && f != 52'd0) begin
      ires = '0;
    end else if (s) begin
      ires = (big || mag > lim) ? (64'd0 - lim) : (64'd0 - mag);
    end else begin
      ires = (big || mag > lim - 64'd1) ? (lim - 64'd1) : mag;
    end

    if (dst_type_i == ntc_pkg::TY_F64) begin
      res_o = d;
    end else if (dst_type_i == ntc_pkg::TY_F32) begin
      res_o = {32'd0, f32r};
    end else begin
      res_o = ires;
    end
  end

endmodule
`default_nettype wire

### sv/numeric_type_converter.sv
// numeric type converter top: input register, conversion logic, result register
// depends on ntc_pkg, ntc_int2flt, ntc_flt_cvt
//
// channel  | ports                      | handshake
// input    | item_i (ntc_in_t)          | start_i && !busy_o
// result   | result_o (ntc_out_t)       | valid_o, one cycle strobe
//
// one beat per cycle; a beat is taken into the input register and its result into the result register
// latency is set by the input register and the result register
// busy_o stays low: the block takes a beat every cycle
// rst_ni clears both valid flags; payload registers are not reset
// results cannot be stalled
`default_nettype none
module numeric_type_converter (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire ntc_pkg::ntc_in_t item_i,
  output logic                  busy_o,
  output logic                  valid_o,
  output ntc_pkg::ntc_out_t     result_o
);

  ntc_pkg::ntc_in_t  in_q;
  ntc_pkg::ntc_out_t out_d, out_q;
  logic              in_vld_q, out_vld_q;
  logic [63:0]       v, ext, i2f, fcv, r;
  logic              neg, bad;

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= start_i && !busy_o;
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) in_q <= item_i;
    if (in_vld_q) out_q <= out_d;
  end

  always_comb begin
    v   = in_q.value_bits & ntc_pkg::type_mask(in_q.in_type);
    neg = ntc_pkg::type_signed(in_q.in_type) && ((v & ~(ntc_pkg::type_mask(in_q.in_type) >> 1))
          != 64'd0);
    ext = neg ? (v | ~ntc_pkg::type_mask(in_q.in_type)) : v;
  end

  ntc_int2flt u_i2f (
    .ext_i    (ext),
    .neg_i    (neg),
    .to_f64_i (in_q.dst_type == ntc_pkg::TY_F64),
    .flt_o    (i2f)
  );

  ntc_flt_cvt u_fcv (
    .v_i        (v),
    .from_f32_i (in_q.in_type == ntc_pkg::TY_F32),
    .dst_type_i (in_q.dst_type),
    .res_o      (fcv)
  );

  always_comb begin
    bad = !ntc_pkg::type_valid(in_q.in_type) || !ntc_pkg::type_valid(in_q.dst_type);
    if (in_q.in_type == in_q.dst_type) begin
      r = v;
    end else if (ntc_pkg::type_float(in_q.in_type)) begin
      r = fcv;
    end else if (ntc_pkg::type_float(in_q.dst_type)) begin
      r = i2f;
    end else begin
      r = ext;
    end
    out_d.result_bits = bad ? 64'd0 : (r & ntc_pkg::type_mask(in_q.dst_type));
    out_d.status      = bad;
  end

  assign valid_o  = out_vld_q;
  assign result_o = out_q;

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> ##1 valid_o) else $error("result strobe missing");
  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(valid_o) |-> $past(in_vld_q)) else $error("result without beat");
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && result_o.status) |-> (result_o.result_bits == 64'd0))
    else $error("invalid code with nonzero result");

endmodule
`default_nettype wire
